[hdl/rgb_5x5_convolution_macros.svh]
// Assertion macros for the 5x5 RGB convolution block.
// Used by the port checker; needs clk and rst_n in the including scope.
`ifndef RGB_5X5_CONVOLUTION_MACROS_SVH
`define RGB_5X5_CONVOLUTION_MACROS_SVH

// Same-cycle implication.
`define RGBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgbc_checker: property violated");

// Next-cycle implication.
`define RGBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgbc_checker: property violated");

`endif

[hdl/rgbc_pkg.sv]
// Shared types and constants of the 5x5 RGB convolution block.
// No dependencies; imported by every module of the block.
package rgbc_pkg;

  localparam int CH_W     = 8;
  localparam int NCH      = 3;
  localparam int PIX_W    = CH_W * NCH;
  localparam int KDIM     = 5;
  localparam int NTAP     = KDIM * KDIM;
  localparam int LANES    = 4;
  localparam int CF_W     = 12;
  localparam int KROW_W   = CF_W * KDIM;
  localparam int ACC_W    = 26;
  localparam int DIV_W    = 16;
  localparam int CFG_W    = 60;
  localparam int CFG_AW   = 3;
  localparam int COL_O_W  = 11;
  localparam int ROW_O_W  = 12;
  localparam int IN_TD_W  = 24;
  localparam int OUT_TD_W = 48;
  localparam int WCMP_W   = 14;
  localparam int HCMP_W   = 15;

  localparam logic [CFG_AW-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_KERNEL_ROW0  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_KERNEL_ROW1  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_KERNEL_ROW2  = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_KERNEL_ROW3  = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_KERNEL_ROW4  = 3'd6;
  localparam logic [CFG_AW-1:0] CFG_DIVISOR      = 3'd7;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [NTAP-1:0][PIX_W-1:0] win_t;
  typedef logic [LANES-1:0][PIX_W-1:0] lanes_t;
  typedef logic [KDIM-1:0][KROW_W-1:0] kern_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic              en;
    logic [LANES-1:0]  lane_we;
  } mem_req_t;

endpackage

[hdl/rgbc_line_mem.sv]
// Line store memory: one word per column holding four rows, per-row write lanes.
// Read-before-write, one cycle read latency. Depends on rgbc_pkg.
module rgbc_line_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  rgbc_pkg::mem_req_t req,
  input  logic [AW-1:0]      addr,
  input  rgbc_pkg::pix_t     wdata,
  output rgbc_pkg::lanes_t   rdata
);
  import rgbc_pkg::*;

  lanes_t mem [DEPTH];
  lanes_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.en) begin
      rdata_r <= mem[addr];
      for (int i = 0; i < LANES; i++) begin
        if (req.lane_we[i]) begin
          mem[addr][i] <= wdata;
        end
      end
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/rgbc_mac.sv]
// Three-channel multiply-accumulate over the 25 window taps, one tap per cycle.
// Depends on rgbc_pkg.
module rgbc_mac #(
  parameter int COEF_BITS = 12
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  rgbc_pkg::win_t  win,
  input  rgbc_pkg::kern_t kern,
  output logic            done,
  output rgbc_pkg::acc_t  acc [rgbc_pkg::NCH]
);
  import rgbc_pkg::*;

  localparam int SH = CF_W - COEF_BITS;

  logic        busy_r;
  logic        done_r;
  logic [4:0]  k_r;
  logic [2:0]  r_r;
  logic [2:0]  c_r;
  acc_t        acc_r [NCH];
  pix_t        sample;
  logic [CF_W-1:0]        field;
  logic signed [CF_W-1:0] coef_sh;
  logic signed [CF_W-1:0] coef;
  logic signed [CH_W+CF_W:0] prod [NCH];

  always_comb begin
    sample  = win[k_r];
    field   = kern[r_r][c_r*CF_W +: CF_W];
    coef_sh = $signed(field << SH);
    coef    = coef_sh >>> SH;
    for (int ch = 0; ch < NCH; ch++) begin
      prod[ch] = $signed({1'b0, sample[ch*CH_W +: CH_W]}) * coef;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && k_r == 5'(NTAP - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      k_r <= '0;
      r_r <= '0;
      c_r <= '0;
      for (int ch = 0; ch < NCH; ch++) begin
        acc_r[ch] <= '0;
      end
    end else if (busy_r) begin
      k_r <= k_r + 5'd1;
      if (c_r == 3'(KDIM - 1)) begin
        c_r <= '0;
        r_r <= r_r + 3'd1;
      end else begin
        c_r <= c_r + 3'd1;
      end
      for (int ch = 0; ch < NCH; ch++) begin
        acc_r[ch] <= acc_r[ch] + ACC_W'(prod[ch]);
      end
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

[hdl/rgbc_div.sv]
// Three-lane restoring divider, one quotient bit per cycle, truncating toward zero.
// Keeps the low 8 bits of each quotient. Depends on rgbc_pkg.
module rgbc_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  rgbc_pkg::acc_t          num [rgbc_pkg::NCH],
  input  logic [rgbc_pkg::DIV_W-1:0] den,
  output logic                    done,
  output logic [rgbc_pkg::CH_W-1:0] quot [rgbc_pkg::NCH]
);
  import rgbc_pkg::*;

  localparam int CW = $clog2(ACC_W);

  logic                 busy_r;
  logic                 done_r;
  logic [CW-1:0]        cnt_r;
  logic [DIV_W-1:0]     den_r;
  logic [NCH-1:0]       neg_r;
  logic [ACC_W-1:0]     quo_r [NCH];
  logic [DIV_W-1:0]     rem_r [NCH];
  logic [DIV_W:0]       sh    [NCH];

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      sh[ch]   = {rem_r[ch], quo_r[ch][ACC_W-1]};
      quot[ch] = neg_r[ch] ? CH_W'(-quo_r[ch][CH_W-1:0]) : quo_r[ch][CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(ACC_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      den_r <= (den == '0) ? DIV_W'(1) : den;
      for (int ch = 0; ch < NCH; ch++) begin
        neg_r[ch] <= num[ch][ACC_W-1];
        quo_r[ch] <= num[ch][ACC_W-1] ? ACC_W'(-num[ch]) : num[ch];
        rem_r[ch] <= '0;
      end
    end else if (busy_r) begin
      cnt_r <= cnt_r + CW'(1);
      for (int ch = 0; ch < NCH; ch++) begin
        if (sh[ch] >= {1'b0, den_r}) begin
          rem_r[ch] <= DIV_W'(sh[ch] - {1'b0, den_r});
          quo_r[ch] <= {quo_r[ch][ACC_W-2:0], 1'b1};
        end else begin
          rem_r[ch] <= sh[ch][DIV_W-1:0];
          quo_r[ch] <= {quo_r[ch][ACC_W-2:0], 1'b0};
        end
      end
    end
  end

  assign done = done_r;

endmodule

[hdl/rgb_5x5_convolution.sv]
// 5x5 RGB convolution filter, top level: config registers, position counters,
// window and sequencing. Depends on rgbc_pkg, rgbc_line_mem, rgbc_mac, rgbc_div.
//
// Pixels arrive in raster order, one per transaction; in_tuser marks the first
// pixel of a frame. Every pixel whose column and row are both at least four
// yields one result for the centre pixel two rows up and two columns left.
// One pixel is in work at a time. A pixel without a result is accepted with
// the line-store read and then shifts the window; one with a result is
// accepted with the line-store read, shifts the window and starts the shared
// multiply-accumulate, runs the 25 taps there, is handed over to the
// bit-serial divider, is handed over again and then loads the output register,
// after any wait for a full output register to drain. A finished result waits
// in the output register while the next pixel is taken. After reset the line
// store is cleared, one column per cycle, over all MAX_WIDTH columns before
// the first pixel is accepted; config writes are taken at any time but belong
// only to idle periods.
module rgb_5x5_convolution #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  parameter int COEF_BITS  = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rgbc_pkg::IN_TD_W-1:0]  in_tdata,   // pixel_red, pixel_green, pixel_blue
  input  logic [0:0]                    in_tuser,   // frame_start
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_red, out_green, out_blue, center_col, center_row, one pad bit
  output logic [rgbc_pkg::OUT_TD_W-1:0] out_tdata,
  input  logic                          cfg_we,
  input  logic [rgbc_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [rgbc_pkg::CFG_W-1:0]    cfg_wdata
);
  import rgbc_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_MAC   = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [11:0]       width_r;
  logic [12:0]       height_r;
  kern_t             kern_r;
  logic [DIV_W-1:0]  divisor_r;

  logic [CW-1:0]     col_cnt_r;
  logic [RW-1:0]     row_cnt_r;
  logic [CW-1:0]     clr_addr_r;
  logic [CW-1:0]     col_r;
  logic [RW-1:0]     row_r;
  logic              hit_r;
  pix_t              pix_r;
  win_t              win_r;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TD_W-1:0] out_tdata_r;

  logic [WCMP_W-1:0] w_ext, w_eff, col_ext, col1;
  logic [HCMP_W-1:0] h_ext, h_eff, row_ext, row1;
  logic [CW-1:0]     col_eff;
  logic [RW-1:0]     row_eff;
  logic              accept;
  logic              load_out;
  mem_req_t          mem_req;
  logic [CW-1:0]     mem_addr;
  pix_t              mem_wdata;
  lanes_t            mem_rdata;
  pix_t              column [KDIM];
  logic              mac_start, mac_done, div_done;
  acc_t              acc [NCH];
  logic [CH_W-1:0]   quot [NCH];
  logic [WCMP_W-1:0] ccol;
  logic [HCMP_W-1:0] crow;

  always_comb begin
    w_ext = WCMP_W'(width_r);
    if (w_ext < WCMP_W'(5))                w_eff = WCMP_W'(5);
    else if (w_ext > WCMP_W'(MAX_WIDTH))   w_eff = WCMP_W'(MAX_WIDTH);
    else                                   w_eff = w_ext;
    h_ext = HCMP_W'(height_r);
    if (h_ext < HCMP_W'(5))                h_eff = HCMP_W'(5);
    else if (h_ext > HCMP_W'(MAX_HEIGHT))  h_eff = HCMP_W'(MAX_HEIGHT);
    else                                   h_eff = h_ext;

    col_eff = (in_tuser[0] || WCMP_W'(col_cnt_r) >= w_eff) ? '0 : col_cnt_r;
    row_eff = (in_tuser[0] || HCMP_W'(row_cnt_r) >= h_eff) ? '0 : row_cnt_r;
    col_ext = WCMP_W'(col_eff);
    row_ext = HCMP_W'(row_eff);
    col1    = col_ext + WCMP_W'(1);
    row1    = row_ext + HCMP_W'(1);
  end

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign load_out  = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);
  assign mac_start = (state_r == ST_LOAD) && hit_r;

  always_comb begin
    mem_req.en      = 1'b0;
    mem_req.lane_we = '0;
    mem_addr        = col_eff;
    mem_wdata       = in_tdata;
    if (state_r == ST_CLEAR) begin
      mem_req.en      = 1'b1;
      mem_req.lane_we = '1;
      mem_addr        = clr_addr_r;
      mem_wdata       = '0;
    end else if (accept) begin
      mem_req.en      = 1'b1;
      mem_req.lane_we = LANES'(1) << row_eff[1:0];
    end
  end

  always_comb begin
    for (int r = 0; r < LANES; r++) begin
      column[r] = mem_rdata[2'(row_r[1:0] + 2'(r))];
    end
    column[KDIM-1] = pix_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_addr_r == CW'(MAX_WIDTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = hit_r ? ST_MAC : ST_IDLE;
      ST_MAC:   if (mac_done) state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_OUT;
      ST_OUT:   if (load_out) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (load_out)        out_tvalid_nxt = 1'b1;
    else if (out_tready) out_tvalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      out_tvalid_r <= 1'b0;
      col_cnt_r    <= '0;
      row_cnt_r    <= '0;
      width_r      <= 12'd2048;
      height_r     <= 13'd4096;
      kern_r       <= {KROW_W'(0), KROW_W'(0), KROW_W'(4096), KROW_W'(0), KROW_W'(0)};
      divisor_r    <= DIV_W'(1);
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + CW'(1);
      end
      if (accept) begin
        if (col1 >= w_eff) begin
          col_cnt_r <= '0;
          row_cnt_r <= (row1 >= h_eff) ? '0 : RW'(row1);
        end else begin
          col_cnt_r <= CW'(col1);
          row_cnt_r <= row_eff;
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_IMAGE_WIDTH:  width_r   <= cfg_wdata[11:0];
          CFG_IMAGE_HEIGHT: height_r  <= cfg_wdata[12:0];
          CFG_KERNEL_ROW0:  kern_r[0] <= cfg_wdata;
          CFG_KERNEL_ROW1:  kern_r[1] <= cfg_wdata;
          CFG_KERNEL_ROW2:  kern_r[2] <= cfg_wdata;
          CFG_KERNEL_ROW3:  kern_r[3] <= cfg_wdata;
          CFG_KERNEL_ROW4:  kern_r[4] <= cfg_wdata;
          CFG_DIVISOR:      divisor_r <= cfg_wdata[DIV_W-1:0];
          default:          divisor_r <= divisor_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r <= in_tdata;
      col_r <= col_eff;
      row_r <= row_eff;
      hit_r <= (col_ext >= WCMP_W'(4)) && (row_ext >= HCMP_W'(4));
    end
    if (state_r == ST_LOAD) begin
      for (int r = 0; r < KDIM; r++) begin
        for (int c = 0; c < KDIM - 1; c++) begin
          win_r[r*KDIM + c] <= win_r[r*KDIM + c + 1];
        end
        win_r[r*KDIM + KDIM - 1] <= column[r];
      end
    end
  end

  assign ccol = WCMP_W'(col_r) - WCMP_W'(2);
  assign crow = HCMP_W'(row_r) - HCMP_W'(2);

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_tdata_r <= {1'b0, crow[ROW_O_W-1:0], ccol[COL_O_W-1:0],
                      quot[2], quot[1], quot[0]};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  rgbc_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk   (clk),
    .req   (mem_req),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  rgbc_mac #(
    .COEF_BITS (COEF_BITS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_start),
    .win   (win_r),
    .kern  (kern_r),
    .done  (mac_done),
    .acc   (acc)
  );

  rgbc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_done),
    .num   (acc),
    .den   (divisor_r),
    .done  (div_done),
    .quot  (quot)
  );

endmodule

[hdl/rgbc_checker.sv]
// Port-level checker for the 5x5 RGB convolution block, bound to the top level.
// Depends on rgbc_pkg and rgb_5x5_convolution_macros.svh.
`include "rgb_5x5_convolution_macros.svh"

module rgbc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [rgbc_pkg::OUT_TD_W-1:0] out_tdata
);
  import rgbc_pkg::*;

  `RGBC_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `RGBC_ASSERT_NXT(a_one_in_flight, in_tvalid && in_tready, !in_tready)
  `RGBC_ASSERT_NXT(a_no_early_out, in_tvalid && in_tready, !$rose(out_tvalid))
  `RGBC_ASSERT_IMP(a_center_range, out_tvalid, out_tdata[34:24] >= 11'd2 && out_tdata[46:35] >= 12'd2)

endmodule

bind rgb_5x5_convolution rgbc_checker u_rgbc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
